// ===== rtl/core/snu_pkg.sv =====
// shared types, widths and codes of the surface normal unit
package snu_pkg;

    typedef enum logic [1:0] {
        KIND_SPHERE   = 2'd0,
        KIND_CYLINDER = 2'd1,
        KIND_PLANE    = 2'd2,
        KIND_UNKNOWN  = 2'd3
    } t_kind;

    localparam int CW        = 32;            // coordinate width, Q16.16
    localparam int DW        = CW + 2;        // hit minus centre
    localparam int VW        = CW + 6;        // vector into a normaliser
    localparam int MW        = VW - 1;        // magnitude of such a vector
    localparam int PW        = $clog2(MW);    // leading one position
    localparam int MSW       = 30;            // block-shifted magnitude
    localparam int MAG_TOP   = MSW - 1;       // leading one lands here
    localparam int SQW       = 2 * MSW + 2;   // sum of squares
    localparam int RTW       = SQW / 2;       // square root
    localparam int SRW       = RTW + 4;       // root remainder
    localparam int OUT_FRAC  = 14;
    localparam int AXIS_FRAC = 28;
    localparam int NMW       = MSW + AXIS_FRAC + 1;  // dividend
    localparam int QW        = AXIS_FRAC + 1;        // quotient
    localparam int DRW       = RTW + 1;              // divider remainder
    localparam int UW        = QW + 1;               // signed unit component
    localparam int DOTW      = DW + 2;               // dot product
    localparam int NRMW      = 16;                   // output component
    localparam int UNIT_ONE  = 1 << OUT_FRAC;

    typedef struct packed {
        t_kind                kind;
        logic [2:0][DW-1:0]   d;
        logic [2:0][CW-1:0]   a;
    } t_side_a;

    typedef struct packed {
        t_kind kind;
        logic  bad;
    } t_side_b;

    localparam int SIDE_W = $bits(t_side_a);
    localparam int SB_W   = $bits(t_side_b);

    typedef struct packed {
        logic vld;
        logic ok;
    } t_norm_stat;

endpackage

// ===== rtl/core/snu_if.sv =====
// request and result channels of the surface normal unit
interface snu_in_if
    import snu_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic signed [CW-1:0]  center_x;
    logic signed [CW-1:0]  center_y;
    logic signed [CW-1:0]  center_z;
    logic signed [CW-1:0]  axis_x;
    logic signed [CW-1:0]  axis_y;
    logic signed [CW-1:0]  axis_z;
    logic signed [CW-1:0]  hit_x;
    logic signed [CW-1:0]  hit_y;
    logic signed [CW-1:0]  hit_z;

    modport source (
        output valid, kind, center_x, center_y, center_z,
        output axis_x, axis_y, axis_z, hit_x, hit_y, hit_z,
        input  ready
    );
    modport sink (
        input  valid, kind, center_x, center_y, center_z,
        input  axis_x, axis_y, axis_z, hit_x, hit_y, hit_z,
        output ready
    );
endinterface

interface snu_out_if
    import snu_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [NRMW-1:0]  normal_x;
    logic signed [NRMW-1:0]  normal_y;
    logic signed [NRMW-1:0]  normal_z;
    logic                    degenerate;

    modport source (
        output valid, normal_x, normal_y, normal_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, degenerate,
        output ready
    );
endinterface

// ===== rtl/core/snu_norm.sv =====
// pipelined vector normaliser: block shift, sum of squares, root, divide
module snu_norm
    import snu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_frac_long,
    input  logic                i_vld,
    input  logic [2:0][VW-1:0]  i_vec,
    input  logic [SIDE_W-1:0]   i_side,
    output t_norm_stat          o_stat,
    output logic [2:0][UW-1:0]  o_u,
    output logic [SIDE_W-1:0]   o_side
);

    typedef struct packed {
        logic                 zero;
        logic [2:0]           neg;
        logic [2:0][MSW-1:0]  m;
        logic [SIDE_W-1:0]    side;
    } t_ncar;

    // magnitudes
    logic [VW-1:0]       n1_abs [3];
    logic                r_v1;
    logic [2:0]          r_neg1;
    logic [2:0][MW-1:0]  r_mag1;
    logic [SIDE_W-1:0]   r_side1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_abs[i] = i_vec[i][VW-1] ? (~i_vec[i] + VW'(1)) : i_vec[i];
        end
    end

    // leading one of the largest magnitude
    logic [MW-1:0]       n2_or;
    logic [PW-1:0]       n2_pos;
    logic                r_v2;
    logic [2:0]          r_neg2;
    logic [2:0][MW-1:0]  r_mag2;
    logic [PW-1:0]       r_pos2;
    logic                r_zero2;
    logic [SIDE_W-1:0]   r_side2;

    always_comb begin
        n2_or  = r_mag1[0] | r_mag1[1] | r_mag1[2];
        n2_pos = '0;
        for (int b = 0; b < MW; b++) begin
            if (n2_or[b]) n2_pos = PW'(b);
        end
    end

    // block shift
    logic [MW-1:0]       n3_s [3];
    t_ncar               n3_c;
    logic                r_v3;
    t_ncar               r_c3;

    always_comb begin
        n3_c.zero = r_zero2;
        n3_c.neg  = r_neg2;
        n3_c.side = r_side2;
        for (int i = 0; i < 3; i++) begin
            if (r_pos2 > PW'(MAG_TOP)) n3_s[i] = r_mag2[i] >> (r_pos2 - PW'(MAG_TOP));
            else                       n3_s[i] = r_mag2[i] << (PW'(MAG_TOP) - r_pos2);
            n3_c.m[i] = n3_s[i][MSW-1:0];
        end
    end

    // squares
    logic                    r_v4;
    t_ncar                   r_c4;
    logic [2:0][2*MSW-1:0]   r_sq4;

    // square root, one result bit a stage
    logic                r_sv    [RTW+1];
    t_ncar               r_sc    [RTW+1];
    logic [SQW-1:0]      r_sx    [RTW+1];
    logic [SRW-1:0]      r_srem  [RTW+1];
    logic [RTW-1:0]      r_sroot [RTW+1];
    logic [SRW-1:0]      s_cur   [RTW];
    logic [SRW-1:0]      s_try   [RTW];
    logic                s_ge    [RTW];

    always_comb begin
        for (int k = 0; k < RTW; k++) begin
            s_cur[k] = {r_srem[k][SRW-3:0], r_sx[k][SQW-1 -: 2]};
            s_try[k] = SRW'({r_sroot[k], 2'b01});
            s_ge[k]  = s_cur[k] >= s_try[k];
        end
    end

    // divide, one quotient bit a stage
    logic [NMW-1:0]          d_num  [3];
    logic                    r_dv   [QW+1];
    t_ncar                   r_dc   [QW+1];
    logic [RTW-1:0]          r_dlen [QW+1];
    logic [2:0][DRW-1:0]     r_drem [QW+1];
    logic [2:0][QW-1:0]      r_dlo  [QW+1];
    logic [2:0][QW-1:0]      r_dq   [QW+1];
    logic [DRW-1:0]          d_cur  [QW][3];
    logic                    d_ge   [QW][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_num[i] = (i_frac_long ? (NMW'(r_sc[RTW].m[i]) << AXIS_FRAC)
                                    : (NMW'(r_sc[RTW].m[i]) << OUT_FRAC))
                     + NMW'(r_sroot[RTW] >> 1);
        end
        for (int k = 0; k < QW; k++) begin
            for (int i = 0; i < 3; i++) begin
                d_cur[k][i] = {r_drem[k][i][DRW-2:0], r_dlo[k][i][QW-1]};
                d_ge[k][i]  = d_cur[k][i] >= DRW'(r_dlen[k]);
            end
        end
    end

    // signed result
    logic                r_ov;
    logic                r_ozero;
    logic [2:0][UW-1:0]  r_ou;
    logic [SIDE_W-1:0]   r_oside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
            for (int k = 0; k <= RTW; k++) r_sv[k] <= 1'b0;
            for (int k = 0; k <= QW; k++)  r_dv[k] <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_vld;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_sv[0] <= r_v4;
            for (int k = 0; k < RTW; k++) r_sv[k+1] <= r_sv[k];
            r_dv[0] <= r_sv[RTW];
            for (int k = 0; k < QW; k++) r_dv[k+1] <= r_dv[k];
            r_ov    <= r_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_neg1[i] <= i_vec[i][VW-1];
                r_mag1[i] <= n1_abs[i][MW-1:0];
            end
            r_side1 <= i_side;

            r_neg2  <= r_neg1;
            r_mag2  <= r_mag1;
            r_pos2  <= n2_pos;
            r_zero2 <= (n2_or == '0);
            r_side2 <= r_side1;

            r_c3 <= n3_c;

            r_c4 <= r_c3;
            for (int i = 0; i < 3; i++) r_sq4[i] <= r_c3.m[i] * r_c3.m[i];

            r_sc[0]    <= r_c4;
            r_sx[0]    <= SQW'(r_sq4[0]) + SQW'(r_sq4[1]) + SQW'(r_sq4[2]);
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
            for (int k = 0; k < RTW; k++) begin
                r_sc[k+1]    <= r_sc[k];
                r_sx[k+1]    <= r_sx[k] << 2;
                r_srem[k+1]  <= s_ge[k] ? (s_cur[k] - s_try[k]) : s_cur[k];
                r_sroot[k+1] <= {r_sroot[k][RTW-2:0], s_ge[k]};
            end

            r_dc[0]   <= r_sc[RTW];
            r_dlen[0] <= r_sroot[RTW];
            for (int i = 0; i < 3; i++) begin
                r_drem[0][i] <= DRW'(d_num[i][NMW-1:QW]);
                r_dlo[0][i]  <= d_num[i][QW-1:0];
                r_dq[0][i]   <= '0;
            end
            for (int k = 0; k < QW; k++) begin
                r_dc[k+1]   <= r_dc[k];
                r_dlen[k+1] <= r_dlen[k];
                for (int i = 0; i < 3; i++) begin
                    r_drem[k+1][i] <= d_ge[k][i] ? (d_cur[k][i] - DRW'(r_dlen[k]))
                                                 : d_cur[k][i];
                    r_dlo[k+1][i]  <= r_dlo[k][i] << 1;
                    r_dq[k+1][i]   <= {r_dq[k][i][QW-2:0], d_ge[k][i]};
                end
            end

            r_ozero <= r_dc[QW].zero;
            r_oside <= r_dc[QW].side;
            for (int i = 0; i < 3; i++) begin
                r_ou[i] <= r_dc[QW].neg[i] ? (~UW'(r_dq[QW][i]) + UW'(1))
                                           : UW'(r_dq[QW][i]);
            end
        end
    end

    assign o_stat.vld = r_ov;
    assign o_stat.ok  = !r_ozero;
    assign o_u        = r_ou;
    assign o_side     = r_oside;

endmodule

// ===== rtl/core/snu_cyl.sv =====
// cylinder projection removal and selection of the vector to normalise
module snu_cyl
    import snu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  t_norm_stat          i_stat,
    input  logic [2:0][UW-1:0]  i_u,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_vld,
    output logic [2:0][VW-1:0]  o_vec,
    output logic [SIDE_W-1:0]   o_side
);

    localparam int PDW = DW + UW;
    localparam int PPW = DOTW + UW;

    t_side_a             sa_in;
    logic [DW-1:0]       c1_dm [3];
    logic [UW-1:0]       c1_um [3];

    assign sa_in = t_side_a'(i_side);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c1_dm[i] = sa_in.d[i][DW-1] ? (~sa_in.d[i] + DW'(1)) : sa_in.d[i];
            c1_um[i] = i_u[i][UW-1] ? (~i_u[i] + UW'(1)) : i_u[i];
        end
    end

    // stage 1: d times unit axis
    logic                 r_v1, r_ok1;
    t_side_a              r_sa1;
    logic [2:0][UW-1:0]   r_u1;
    logic [2:0][PDW-1:0]  r_p1;
    logic [2:0]           r_sg1;

    // stage 2: rounded terms summed into dot
    logic [PDW-1:0]       c2_t [3];
    logic [DOTW-1:0]      c2_s [3];
    logic                 r_v2, r_ok2;
    t_side_a              r_sa2;
    logic [2:0][UW-1:0]   r_u2;
    logic [DOTW-1:0]      r_dot2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c2_t[i] = (r_p1[i] + (PDW'(1) << (AXIS_FRAC - 1))) >> AXIS_FRAC;
            c2_s[i] = r_sg1[i] ? (~c2_t[i][DOTW-1:0] + DOTW'(1)) : c2_t[i][DOTW-1:0];
        end
    end

    // stage 3: dot times unit axis
    logic [DOTW-1:0]      c3_dm;
    logic [UW-1:0]        c3_um [3];
    logic                 r_v3, r_ok3;
    t_side_a              r_sa3;
    logic [2:0][PPW-1:0]  r_pp3;
    logic [2:0]           r_sg3;

    always_comb begin
        c3_dm = r_dot2[DOTW-1] ? (~r_dot2 + DOTW'(1)) : r_dot2;
        for (int i = 0; i < 3; i++) begin
            c3_um[i] = r_u2[i][UW-1] ? (~r_u2[i] + UW'(1)) : r_u2[i];
        end
    end

    // stage 4: perpendicular part and kind select
    logic [PPW-1:0]       c4_pm [3];
    logic [VW-1:0]        c4_pj [3];
    logic [2:0][VW-1:0]   n_vec;
    t_side_b              n_sb;
    logic [SIDE_W-1:0]    n_side;
    logic                 r_v4;
    logic [2:0][VW-1:0]   r_vec4;
    logic [SIDE_W-1:0]    r_side4;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c4_pm[i] = (r_pp3[i] + (PPW'(1) << (AXIS_FRAC - 1))) >> AXIS_FRAC;
            c4_pj[i] = r_sg3[i] ? (~c4_pm[i][VW-1:0] + VW'(1)) : c4_pm[i][VW-1:0];
        end
        n_sb.kind = r_sa3.kind;
        n_sb.bad  = 1'b0;
        for (int i = 0; i < 3; i++) begin
            case (r_sa3.kind)
                KIND_SPHERE:   n_vec[i] = VW'($signed(r_sa3.d[i]));
                KIND_CYLINDER: n_vec[i] = VW'($signed(r_sa3.d[i])) - c4_pj[i];
                KIND_PLANE:    n_vec[i] = VW'($signed(r_sa3.a[i]));
                default:       n_vec[i] = '0;
            endcase
        end
        case (r_sa3.kind)
            KIND_CYLINDER: n_sb.bad = !r_ok3;
            KIND_UNKNOWN:  n_sb.bad = 1'b1;
            default:       n_sb.bad = 1'b0;
        endcase
        n_side             = '0;
        n_side[SB_W-1:0]   = n_sb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_stat.vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok1 <= i_stat.ok;
            r_sa1 <= sa_in;
            r_u1  <= i_u;
            for (int i = 0; i < 3; i++) begin
                r_p1[i]  <= PDW'(c1_dm[i]) * PDW'(c1_um[i]);
                r_sg1[i] <= sa_in.d[i][DW-1] ^ i_u[i][UW-1];
            end

            r_ok2  <= r_ok1;
            r_sa2  <= r_sa1;
            r_u2   <= r_u1;
            r_dot2 <= c2_s[0] + c2_s[1] + c2_s[2];

            r_ok3 <= r_ok2;
            r_sa3 <= r_sa2;
            for (int i = 0; i < 3; i++) begin
                r_pp3[i] <= PPW'(c3_dm) * PPW'(c3_um[i]);
                r_sg3[i] <= r_dot2[DOTW-1] ^ r_u2[i][UW-1];
            end

            r_vec4  <= n_vec;
            r_side4 <= n_side;
        end
    end

    assign o_vld  = r_v4;
    assign o_vec  = r_vec4;
    assign o_side = r_side4;

endmodule

// ===== rtl/core/surface_normal_unit_core.sv =====
// surface normal unit top level: input stage, two normalisers, cylinder stage, output register
// throughput: one request per cycle; the whole pipeline holds while the output waits
// the two normalisers each hold a 31-stage root and a 29-stage divider
// reset clears every valid bit at once; payload registers are not reset
module surface_normal_unit_core
    import snu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    snu_in_if.sink     i_in,
    snu_out_if.source  o_out
);

    logic                 en;
    logic                 r_v0;
    t_kind                r_kind0;
    logic [2:0][DW-1:0]   r_d0;
    logic [2:0][CW-1:0]   r_a0;
    t_side_a              sa0;
    logic [2:0][VW-1:0]   vec_a;

    logic [CW-1:0]        in_c [3];
    logic [CW-1:0]        in_a [3];
    logic [CW-1:0]        in_h [3];

    t_norm_stat           stat_a, stat_b;
    logic [2:0][UW-1:0]   u_a, u_b;
    logic [SIDE_W-1:0]    side_a_in, side_a_out, side_b_in, side_b_out;
    logic                 cyl_vld;
    logic [2:0][VW-1:0]   vec_b;
    t_side_b              sb;
    logic                 res_ok;

    logic                 r_ov;
    logic [2:0][NRMW-1:0] r_nrm;
    logic                 r_deg;

    assign en         = !r_ov || o_out.ready;
    assign i_in.ready = en;

    assign in_c[0] = i_in.center_x;
    assign in_c[1] = i_in.center_y;
    assign in_c[2] = i_in.center_z;
    assign in_a[0] = i_in.axis_x;
    assign in_a[1] = i_in.axis_y;
    assign in_a[2] = i_in.axis_z;
    assign in_h[0] = i_in.hit_x;
    assign in_h[1] = i_in.hit_y;
    assign in_h[2] = i_in.hit_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v0 <= i_in.valid;
            r_ov <= stat_b.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kind0 <= t_kind'(i_in.kind);
            for (int i = 0; i < 3; i++) begin
                r_d0[i] <= DW'($signed(in_h[i])) - DW'($signed(in_c[i]));
                r_a0[i] <= in_a[i];
            end
            r_deg <= !res_ok;
            for (int i = 0; i < 3; i++) begin
                r_nrm[i] <= res_ok ? u_b[i][NRMW-1:0] : '0;
            end
        end
    end

    always_comb begin
        sa0.kind = r_kind0;
        sa0.d    = r_d0;
        sa0.a    = r_a0;
        for (int i = 0; i < 3; i++) vec_a[i] = VW'($signed(r_a0[i]));
    end

    assign side_a_in = sa0;

    // cylinder axis to Q2.28
    snu_norm u_norm_axis (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_frac_long (1'b1),
        .i_vld       (r_v0),
        .i_vec       (vec_a),
        .i_side      (side_a_in),
        .o_stat      (stat_a),
        .o_u         (u_a),
        .o_side      (side_a_out)
    );

    snu_cyl u_cyl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_stat  (stat_a),
        .i_u     (u_a),
        .i_side  (side_a_out),
        .o_vld   (cyl_vld),
        .o_vec   (vec_b),
        .o_side  (side_b_in)
    );

    // final normal to Q2.14
    snu_norm u_norm_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_frac_long (1'b0),
        .i_vld       (cyl_vld),
        .i_vec       (vec_b),
        .i_side      (side_b_in),
        .o_stat      (stat_b),
        .o_u         (u_b),
        .o_side      (side_b_out)
    );

    assign sb     = t_side_b'(side_b_out[SB_W-1:0]);
    assign res_ok = stat_b.ok && !sb.bad;

    assign o_out.valid      = r_ov;
    assign o_out.normal_x   = r_nrm[0];
    assign o_out.normal_y   = r_nrm[1];
    assign o_out.normal_z   = r_nrm[2];
    assign o_out.degenerate = r_deg;

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.degenerate |->
            o_out.normal_x == '0 && o_out.normal_y == '0 && o_out.normal_z == '0)
        else $error("degenerate result with nonzero normal");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.degenerate |->
            $signed(o_out.normal_x) <= $signed(NRMW'(UNIT_ONE)) &&
            $signed(o_out.normal_x) >= -$signed(NRMW'(UNIT_ONE)) &&
            $signed(o_out.normal_y) <= $signed(NRMW'(UNIT_ONE)) &&
            $signed(o_out.normal_y) >= -$signed(NRMW'(UNIT_ONE)) &&
            $signed(o_out.normal_z) <= $signed(NRMW'(UNIT_ONE)) &&
            $signed(o_out.normal_z) >= -$signed(NRMW'(UNIT_ONE)))
        else $error("normal component beyond unit length");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v0 && !en |=> r_v0 && $stable(r_d0) && $stable(r_kind0))
        else $error("input stage changed while stalled");

    a_out_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat_b.vld && !en |=> stat_b.vld && $stable(u_b))
        else $error("normaliser result changed while stalled");

endmodule
